>>> sv/i2cws_pkg.sv
// Package: shared types, codes and the pin-write table of the I2C write sequencer.
package i2cws_pkg;

  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;
  localparam int ADDR_MAX = 8'h7F;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NACK        = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ARGUMENT    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ADDRESS     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_UNSUPPORTED = 3'd4;

  // Configuration register indexes
  localparam logic [0:0] REG_TARGET_ADDRESS = 1'd0;
  localparam logic [0:0] REG_FORCE_ACK      = 1'd1;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_BUS_IDLE,
    PH_START,
    PH_ADDR,
    PH_ADDR_ACK,
    PH_DATA,
    PH_DATA_ACK,
    PH_STOP,
    PH_STATUS
  } phase_t;

  // One pin write: which line, what level, and whether it ends the phase step run
  typedef struct packed {
    logic scl_sel;
    logic level;
    logic last;
  } pin_op_t;

  // Pin write for a phase and its step; bit_val is the byte bit being sent
  function automatic pin_op_t pin_op(phase_t phase, logic [1:0] step, logic bit_val);
    pin_op_t op;
    op = '{scl_sel: 1'b0, level: 1'b1, last: 1'b1};
    case (phase)
      PH_BUS_IDLE: begin
        op.scl_sel = (step == 2'd1);
        op.level   = 1'b1;
        op.last    = (step == 2'd1);
      end
      PH_START: begin
        op.scl_sel = step[0];
        op.level   = ~step[1];
        op.last    = (step == 2'd3);
      end
      PH_STOP: begin
        op.scl_sel = (step == 2'd1);
        op.level   = (step != 2'd0);
        op.last    = (step == 2'd2);
      end
      PH_ADDR, PH_DATA: begin
        op.scl_sel = (step != 2'd0);
        op.level   = (step == 2'd0) ? bit_val : (step == 2'd1);
        op.last    = (step == 2'd2);
      end
      PH_ADDR_ACK, PH_DATA_ACK: begin
        op.scl_sel = (step != 2'd0);
        op.level   = (step != 2'd2);
        op.last    = (step == 2'd2);
      end
      default: begin
        op = '{scl_sel: 1'b0, level: 1'b1, last: 1'b1};
      end
    endcase
    return op;
  endfunction

endpackage

>>> sv/i2cws_if.sv
// Interfaces: input byte channel and pin-write result channel.
interface i2cws_item_if;
  import i2cws_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              first_of_message;
  logic              last_of_message;
  logic              last_of_transfer;
  logic              read_request;
  logic              restart_request;
  logic              stop_request;
  logic              address_ack_level;
  logic              data_ack_level;

  modport source (
    output valid, data_byte, first_of_message, last_of_message, last_of_transfer,
           read_request, restart_request, stop_request, address_ack_level,
           data_ack_level,
    input  ready
  );
  modport sink (
    input  valid, data_byte, first_of_message, last_of_message, last_of_transfer,
           read_request, restart_request, stop_request, address_ack_level,
           data_ack_level,
    output ready
  );
endinterface

interface i2cws_result_if;
  import i2cws_pkg::*;
  logic                valid;
  logic                ready;
  logic                scl_level;
  logic                sda_level;
  logic                pin_event;
  logic [STATUS_W-1:0] status;
  logic                transfer_done;
  logic                last_result;

  modport source (
    output valid, scl_level, sda_level, pin_event, status, transfer_done, last_result,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, pin_event, status, transfer_done, last_result,
    output ready
  );
endinterface

>>> sv/i2c_master_write_sequencer.sv
// Top level: I2C master write sequencer producing bit-bang SCL/SDA pin writes.
//
// Usage: each transaction on cmd carries one message byte plus framing flags
// and the sampled ack levels. The block answers on res with the ordered pin
// writes (pin_event 1) for that byte, then one status-only result that carries
// last_result. The first byte of a transfer drives the bus idle, the first byte
// of a message sends a start and the address byte with its ack slot, every byte
// is sent MSB first with its ack slot, and a stop closes a message on request.
// Errors end with a stop (where the bus is open) and a nonzero status; bytes
// are then dropped up to the one marked last_of_transfer.
// cmd.ready is high only while the sequencer is idle. One result leaves per
// cycle while res is ready; a byte gives up to 63 pin writes plus the status.
// The rate is set by the single step counter and byte shift register that
// walk every pin write in turn. A dropped byte gives no result.
// A stalled res holds the result register and freezes the sequencer.
// Reset (rst, synchronous) returns to idle with both lines held high, no open
// transfer, target_address 0 and force_ack 1.
module i2c_master_write_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  i2cws_item_if.sink           cmd,
  i2cws_result_if.source       res,
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_index,
  input  logic [i2cws_pkg::DATA_W-1:0] cfg_data
);
  import i2cws_pkg::*;

  // Configuration
  logic [DATA_W-1:0] target_address;
  logic              force_ack;

  // Sequencer control
  phase_t            state, state_next;
  logic [1:0]        step, step_next;
  logic [2:0]        bitcnt, bitcnt_next;
  logic [DATA_W-1:0] shreg, shreg_next;
  logic              in_transfer, in_transfer_next;
  logic              first_message_pending, first_message_pending_next;
  logic              discarding, discarding_next;
  logic              scl_held, scl_held_next;
  logic              sda_held, sda_held_next;
  logic [STATUS_W-1:0] pend_status, pend_status_next;
  logic              pend_fail, pend_fail_next;

  // Latched item fields
  logic [DATA_W-1:0] data_byte;
  logic              last_of_transfer;
  logic              stop_after;
  logic              read_request;
  logic              address_ack_level;
  logic              data_ack_level;

  // Result register
  logic                out_valid, out_valid_next;
  logic                out_scl, out_sda, out_pin, out_done;
  logic [STATUS_W-1:0] out_status;

  logic    accept, fire, addr_bad, nack;
  pin_op_t op;

  assign accept   = cmd.valid && cmd.ready;
  assign fire     = (state != PH_IDLE) && (!out_valid || res.ready);
  assign addr_bad = (target_address > DATA_W'(ADDR_MAX));
  assign op       = pin_op(state, step, shreg[DATA_W-1]);
  assign nack     = !force_ack &&
                    ((state == PH_ADDR_ACK) ? address_ack_level : data_ack_level);

  // Next state and sequencer registers
  always_comb begin
    state_next                 = state;
    step_next                  = step;
    bitcnt_next                = bitcnt;
    shreg_next                 = shreg;
    in_transfer_next           = in_transfer;
    first_message_pending_next = first_message_pending;
    discarding_next            = discarding;
    scl_held_next              = scl_held;
    sda_held_next              = sda_held;
    pend_status_next           = pend_status;
    pend_fail_next             = pend_fail;

    if (accept) begin
      pend_status_next = STAT_OK;
      pend_fail_next   = 1'b0;
      step_next        = '0;
      bitcnt_next      = '0;
      if (discarding) begin
        if (cmd.last_of_transfer) discarding_next = 1'b0;
      end else if (!in_transfer) begin
        if (addr_bad) begin
          state_next       = PH_STATUS;
          pend_status_next = STAT_ADDRESS;
          pend_fail_next   = 1'b1;
        end else begin
          state_next                 = PH_BUS_IDLE;
          in_transfer_next           = 1'b1;
          first_message_pending_next = 1'b1;
        end
      end else if (cmd.first_of_message || first_message_pending) begin
        if (first_message_pending || cmd.restart_request) begin
          state_next = PH_START;
        end else begin
          state_next       = PH_STOP;
          pend_status_next = STAT_ARGUMENT;
          pend_fail_next   = 1'b1;
        end
      end else begin
        state_next = PH_DATA;
        shreg_next = cmd.data_byte;
      end
    end else if (fire && state == PH_STATUS) begin
      // Close out the item; end the transfer on its last byte or on failure
      state_next = PH_IDLE;
      if (last_of_transfer || pend_fail) begin
        in_transfer_next           = 1'b0;
        first_message_pending_next = 1'b1;
        discarding_next            = pend_fail && !last_of_transfer;
      end
    end else if (fire) begin
      // Drive one pin write and walk the phase
      if (op.scl_sel) scl_held_next = op.level;
      else            sda_held_next = op.level;
      step_next = step + 2'd1;
      if (op.last) begin
        step_next = '0;
        case (state)
          PH_BUS_IDLE: state_next = PH_START;
          PH_START: begin
            first_message_pending_next = 1'b0;
            if (addr_bad) begin
              state_next       = PH_STOP;
              pend_status_next = STAT_ADDRESS;
              pend_fail_next   = 1'b1;
            end else begin
              state_next = PH_ADDR;
              shreg_next = {target_address[DATA_W-2:0], read_request};
            end
          end
          PH_ADDR, PH_DATA: begin
            shreg_next  = {shreg[DATA_W-2:0], 1'b0};
            bitcnt_next = bitcnt + 3'd1;
            if (bitcnt == 3'd7) begin
              state_next = (state == PH_ADDR) ? PH_ADDR_ACK : PH_DATA_ACK;
            end
          end
          PH_ADDR_ACK: begin
            if (nack) begin
              state_next       = PH_STOP;
              pend_status_next = STAT_NACK;
              pend_fail_next   = 1'b1;
            end else if (read_request) begin
              state_next       = PH_STOP;
              pend_status_next = STAT_UNSUPPORTED;
              pend_fail_next   = 1'b1;
            end else begin
              state_next = PH_DATA;
              shreg_next = data_byte;
            end
          end
          PH_DATA_ACK: begin
            if (nack) begin
              state_next       = PH_STOP;
              pend_status_next = STAT_NACK;
              pend_fail_next   = 1'b1;
            end else if (stop_after) begin
              state_next = PH_STOP;
            end else begin
              state_next = PH_STATUS;
            end
          end
          PH_STOP: state_next = PH_STATUS;
          default: state_next = PH_IDLE;
        endcase
      end
    end
  end

  // Result register contents
  always_comb begin
    out_valid_next = out_valid && !res.ready;
    if (fire) out_valid_next = 1'b1;
  end

  assign cmd.ready         = (state == PH_IDLE);
  assign res.valid         = out_valid;
  assign res.scl_level     = out_scl;
  assign res.sda_level     = out_sda;
  assign res.pin_event     = out_pin;
  assign res.status        = out_status;
  assign res.transfer_done = out_done;
  assign res.last_result   = !out_pin;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= PH_IDLE;
      step                  <= '0;
      bitcnt                <= '0;
      in_transfer           <= 1'b0;
      first_message_pending <= 1'b1;
      discarding            <= 1'b0;
      scl_held              <= 1'b1;
      sda_held              <= 1'b1;
      pend_status           <= STAT_OK;
      pend_fail             <= 1'b0;
      out_valid             <= 1'b0;
      target_address        <= '0;
      force_ack             <= 1'b1;
    end else begin
      state                 <= state_next;
      step                  <= step_next;
      bitcnt                <= bitcnt_next;
      in_transfer           <= in_transfer_next;
      first_message_pending <= first_message_pending_next;
      discarding            <= discarding_next;
      scl_held              <= scl_held_next;
      sda_held              <= sda_held_next;
      pend_status           <= pend_status_next;
      pend_fail             <= pend_fail_next;
      out_valid             <= out_valid_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TARGET_ADDRESS: target_address <= cfg_data;
          REG_FORCE_ACK:      force_ack      <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: latch item fields, shift byte, load result
  always_ff @(posedge clk) begin
    shreg <= shreg_next;
    if (accept) begin
      data_byte         <= cmd.data_byte;
      last_of_transfer  <= cmd.last_of_transfer;
      stop_after        <= cmd.last_of_message && cmd.stop_request;
      read_request      <= cmd.read_request;
      address_ack_level <= cmd.address_ack_level;
      data_ack_level    <= cmd.data_ack_level;
    end
    if (fire) begin
      out_scl    <= scl_held_next;
      out_sda    <= sda_held_next;
      out_pin    <= (state != PH_STATUS);
      out_status <= (state == PH_STATUS) ? pend_status : STAT_OK;
      out_done   <= (state == PH_STATUS) && (last_of_transfer || pend_fail);
    end
  end

  // Checks
  a_pin_no_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pin |-> out_status == STAT_OK && !out_done)
    else $error("pin write carries status");

  a_error_ends_transfer: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pin && out_status != STAT_OK |-> out_done)
    else $error("error status without transfer end");

  a_discard_outside: assert property (@(posedge clk) disable iff (rst)
    discarding |-> !in_transfer)
    else $error("discarding inside an open transfer");

  a_bitcnt_in_byte: assert property (@(posedge clk) disable iff (rst)
    bitcnt != 3'd0 |-> state == PH_ADDR || state == PH_DATA)
    else $error("bit counter running outside a byte phase");

  a_status_ends_item: assert property (@(posedge clk) disable iff (rst)
    fire && state == PH_STATUS |=> state == PH_IDLE)
    else $error("sequencer did not return to idle after status");

endmodule
